[sv/yuyv_to_planar_420_converter_macros.svh]
// Assertion macros for the YUYV to planar 4:2:0 converter.
`ifndef YUYV_TO_PLANAR_420_CONVERTER_MACROS_SVH
`define YUYV_TO_PLANAR_420_CONVERTER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define Y2P_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("y2p assertion failed");

// Check a consequent in the cycle after its antecedent.
`define Y2P_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("y2p assertion failed");

`endif

[sv/y2p_pkg.sv]
// Types and constants of the YUYV to planar 4:2:0 converter.
package y2p_pkg;

	localparam int LUMA_ADDR_W   = 24;
	localparam int CHROMA_ADDR_W = 25;
	localparam int BYTE_W        = 8;

	// Configuration port
	localparam int WIDTH_PAIRS_W  = 12;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;
	localparam int CLAMP_W        = 14;
	localparam int WIDTH_PAIRS_RST  = 320;
	localparam int FRAME_HEIGHT_RST = 480;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PAIRS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] luma_first;
		logic [BYTE_W-1:0] chroma_blue;
		logic [BYTE_W-1:0] luma_second;
		logic [BYTE_W-1:0] chroma_red;
	} pix_t;

	typedef struct packed {
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic [BYTE_W-1:0]        luma_out_first;
		logic [BYTE_W-1:0]        luma_out_second;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic [BYTE_W-1:0]        chroma_value;
		logic                     chroma_is_red;
		logic                     frame_done;
	} wr_t;

endpackage

[sv/yuyv_to_planar_420_converter.sv]
// Top level of the YUYV 4:2:2 to planar 4:2:0 write generator.
//
// Each accepted YUYV macropixel (Y0 U Y1 V) yields one write transaction: the
// two luma bytes with their Y plane address, and one chroma byte (U on even
// rows, V on odd rows) with its U or V plane address. The block takes one
// macropixel per clock cycle unless wr_ready holds the output back; a result
// passes through a three stage pipeline (capture and count, multiply, add)
// whose first stage loads on the accepting edge. Column and row counters
// advance on every accepted macropixel and wrap
// to zero after the last one of the frame, which is flagged by frame_done.
// Configuration writes are always taken (cfg_ready is high) and must be
// issued while the pipeline is empty; out of range values are saturated to
// [1, MAX_WIDTH_PAIRS] and [1, MAX_HEIGHT] when written.
`include "yuyv_to_planar_420_converter_macros.svh"

module yuyv_to_planar_420_converter #(
	parameter int MAX_WIDTH_PAIRS = 2048,
	parameter int MAX_HEIGHT      = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  y2p_pkg::pix_t                    pix_data,
	output logic                             wr_valid,
	input  logic                             wr_ready,
	output y2p_pkg::wr_t                     wr_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [y2p_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [y2p_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int WP_W    = $clog2(MAX_WIDTH_PAIRS + 1);
	localparam int H_W     = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W   = (MAX_WIDTH_PAIRS > 1) ? $clog2(MAX_WIDTH_PAIRS) : 1;
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int PLANE_W = WP_W + H_W + 1;
	localparam int LP_W    = ROW_W + 1 + WP_W;
	localparam int CP_W    = ROW_W + WP_W;
	localparam int CMPC_W  = WP_W + 1;
	localparam int CMPR_W  = H_W + 1;
	localparam int LA_W    = y2p_pkg::LUMA_ADDR_W;
	localparam int CA_W    = y2p_pkg::CHROMA_ADDR_W;
	localparam int CL_W    = y2p_pkg::CLAMP_W;

	localparam logic [WP_W-1:0] WP_RST = WP_W'(
		(MAX_WIDTH_PAIRS < y2p_pkg::WIDTH_PAIRS_RST) ? MAX_WIDTH_PAIRS
			: y2p_pkg::WIDTH_PAIRS_RST);
	localparam logic [H_W-1:0] H_RST = H_W'(
		(MAX_HEIGHT < y2p_pkg::FRAME_HEIGHT_RST) ? MAX_HEIGHT
			: y2p_pkg::FRAME_HEIGHT_RST);

	// Configuration registers, held saturated
	logic [WP_W-1:0] wp_q;
	logic [H_W-1:0]  h_q;
	logic [CL_W-1:0] raw_wp, raw_h, sat_wp, sat_h;

	// Frame position counters
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             row_end, frame_end;

	// Pipeline control
	logic v1_q, v2_q, v3_q;
	logic en1, en2, en3;
	logic pix_accept;

	// Stage 1: captured payload and position
	y2p_pkg::pix_t    pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             done_s1;

	// Stage 2: products
	logic [LA_W-1:0]            luma_prod_s2;
	logic [CA_W-1:0]            choff_s2;
	logic [PLANE_W-1:0]         plane_s2;
	logic [COL_W-1:0]           col_s2;
	logic                       odd_s2;
	logic [y2p_pkg::BYTE_W-1:0] y0_s2, y1_s2, chroma_s2;
	logic                       done_s2;

	// Stage 3: result register
	y2p_pkg::wr_t wr_s3;

	// Saturate written values into range
	assign raw_wp = CL_W'(cfg_data[y2p_pkg::WIDTH_PAIRS_W-1:0]);
	assign raw_h  = CL_W'(cfg_data[y2p_pkg::FRAME_HEIGHT_W-1:0]);

	always_comb begin
		if (raw_wp == '0) begin
			sat_wp = CL_W'(1);
		end else if (raw_wp > CL_W'(MAX_WIDTH_PAIRS)) begin
			sat_wp = CL_W'(MAX_WIDTH_PAIRS);
		end else begin
			sat_wp = raw_wp;
		end
		if (raw_h == '0) begin
			sat_h = CL_W'(1);
		end else if (raw_h > CL_W'(MAX_HEIGHT)) begin
			sat_h = CL_W'(MAX_HEIGHT);
		end else begin
			sat_h = raw_h;
		end
	end

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= WP_RST;
			h_q  <= H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				y2p_pkg::CFG_WIDTH_PAIRS:  wp_q <= sat_wp[WP_W-1:0];
				y2p_pkg::CFG_FRAME_HEIGHT: h_q  <= sat_h[H_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance each stage when the one after it is free
	assign en3        = !v3_q || wr_ready;
	assign en2        = !v2_q || en3;
	assign en1        = !v1_q || en2;
	assign pix_ready  = en1;
	assign pix_accept = pix_valid && pix_ready;

	// End of row and end of frame for the current position
	assign row_end   = (CMPC_W'(col_q) + CMPC_W'(1)) >= CMPC_W'(wp_q);
	assign frame_end = row_end && ((CMPR_W'(row_q) + CMPR_W'(1)) >= CMPR_W'(h_q));

	// Step the counters on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= pix_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	// Stage 1: capture payload and position
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_s1  <= pix_data;
			col_s1  <= col_q;
			row_s1  <= row_q;
			done_s1 <= frame_end;
		end
	end

	// Stage 2: row and plane products, pick the chroma byte
	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			luma_prod_s2 <= LA_W'(LP_W'({row_s1, 1'b0}) * LP_W'(wp_q));
			choff_s2     <= CA_W'(CP_W'(row_s1 >> 1) * CP_W'(wp_q) + CP_W'(col_s1));
			plane_s2     <= PLANE_W'({wp_q, 1'b0}) * PLANE_W'(h_q);
			col_s2       <= col_s1;
			odd_s2       <= row_s1[0];
			y0_s2        <= pix_s1.luma_first;
			y1_s2        <= pix_s1.luma_second;
			chroma_s2    <= row_s1[0] ? pix_s1.chroma_red : pix_s1.chroma_blue;
			done_s2      <= done_s1;
		end
	end

	// Stage 3: final address sums into the result register
	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			wr_s3.luma_address    <= luma_prod_s2 + LA_W'({col_s2, 1'b0});
			wr_s3.luma_out_first  <= y0_s2;
			wr_s3.luma_out_second <= y1_s2;
			wr_s3.chroma_address  <= CA_W'(plane_s2) + choff_s2
				+ (odd_s2 ? CA_W'(plane_s2 >> 2) : CA_W'(0));
			wr_s3.chroma_value    <= chroma_s2;
			wr_s3.chroma_is_red   <= odd_s2;
			wr_s3.frame_done      <= done_s2;
		end
	end

	assign wr_valid = v3_q;
	assign wr_data  = wr_s3;

	// Counters wrap after the last macropixel of the frame
	`Y2P_ASSERT_NEXT(a_frame_wrap, pix_accept && frame_end, col_q == '0 && row_q == '0)
	// A row end moves to the start of the next row
	`Y2P_ASSERT_NEXT(a_row_step, pix_accept && row_end && !frame_end,
		col_q == '0 && row_q == $past(row_q) + ROW_W'(1))
	// Inside a row the column moves by one and the row holds
	`Y2P_ASSERT_NEXT(a_col_step, pix_accept && !row_end,
		col_q == $past(col_q) + COL_W'(1) && row_q == $past(row_q))
	// Input is refused only when every stage is full and wr_ready is low
	`Y2P_ASSERT_NOW(a_full_stall, !pix_ready, v1_q && v2_q && v3_q && !wr_ready)

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the YUYV 4:2:2 to planar 4:2:0 write generator.
module testbench;
	import y2p_pkg::*;

	localparam int WIDTH_PAIRS_MAX = 2048;
	localparam int HEIGHT_MAX      = 4096;
	localparam int COL_W           = 11;
	localparam int ROW_W           = 12;
	localparam int REPORT_LIMIT    = 10;
	localparam int RANDOM_PIXELS   = 400;
	localparam int DEEP_ROWS       = 150;

	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_t                  pix_data  = '0;
	logic                  wr_valid;
	logic                  wr_ready  = 1'b0;
	wr_t                   wr_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIDTH_PAIRS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow copy of the converter's registers and counters
	logic [WIDTH_PAIRS_W-1:0]  width_pairs_reg = WIDTH_PAIRS_RST;
	logic [FRAME_HEIGHT_W-1:0] height_reg      = FRAME_HEIGHT_RST;
	logic [COL_W-1:0]          col_count       = '0;
	logic [ROW_W-1:0]          row_count       = '0;

	pix_t        pixel_backlog[$];
	wr_t         planar_writes_due[$];
	wr_t         oldest_write;
	int unsigned pixels_queued  = 0;
	int unsigned pixels_taken   = 0;
	int unsigned mismatch_count = 0;
	int          send_idle_pct  = 16;
	int          recv_idle_pct  = 46;

	yuyv_to_planar_420_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr_data   (wr_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Work out the planar writes for one macropixel and advance the counters
	function automatic wr_t convert_macropixel(pix_t px);
		int unsigned wp, rows, w, plane, col, row, chroma_off, chroma_base;
		bit          odd, row_end, frame_end;
		wr_t         wr;
		wp = (width_pairs_reg == 0) ? 1 :
			((width_pairs_reg > WIDTH_PAIRS_MAX) ? WIDTH_PAIRS_MAX : width_pairs_reg);
		rows = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
		w = 2 * wp;
		plane = w * rows;
		col = col_count;
		row = row_count;
		odd = row_count[0];
		chroma_off = (row >> 1) * wp + col;
		chroma_base = odd ? plane + plane / 4 : plane;
		row_end = (col + 1 >= wp);
		frame_end = row_end && (row + 1 >= rows);

		wr.luma_address    = LUMA_ADDR_W'(row * w + 2 * col);
		wr.luma_out_first  = px.luma_first;
		wr.luma_out_second = px.luma_second;
		wr.chroma_address  = CHROMA_ADDR_W'(chroma_base + chroma_off);
		wr.chroma_value    = odd ? px.chroma_red : px.chroma_blue;
		wr.chroma_is_red   = odd;
		wr.frame_done      = frame_end;

		// Wrap the column at row end, the row at frame end
		if (row_end) begin
			col_count = '0;
			row_count = frame_end ? '0 : row_count + 1'b1;
		end else begin
			col_count = col_count + 1'b1;
		end
		return wr;
	endfunction

	function automatic string show_write(wr_t wr);
		return $sformatf("luma %h:%h/%h chroma %h:%h red %b done %b",
			wr.luma_address, wr.luma_out_first, wr.luma_out_second,
			wr.chroma_address, wr.chroma_value, wr.chroma_is_red, wr.frame_done);
	endfunction

	task automatic queue_pixel(input pix_t px);
		pixel_backlog.push_back(px);
		pixels_queued++;
	endtask

	task automatic queue_random_pixels(input int n);
		repeat (n) queue_pixel(pix_t'($urandom));
	endtask

	// Wait until every macropixel is taken and every write has come back
	task automatic settle();
		while (pixels_taken != pixels_queued || planar_writes_due.size() != 0)
			@(posedge clk);
	endtask

	// Write both frame registers, optionally followed by the unused indexes
	task automatic program_frame(input logic [CFG_DATA_W-1:0] wp,
			input logic [CFG_DATA_W-1:0] rows, input bit poke_spare);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		int                    n;
		idx = '{CFG_WIDTH_PAIRS, CFG_FRAME_HEIGHT, CFG_SPARE_LO, CFG_SPARE_HI};
		val = '{wp, rows, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
		n = poke_spare ? 4 : 2;
		@(posedge clk);
		for (int k = 0; k < n; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			do @(posedge clk); while (!cfg_ready);
			if (idx[k] == CFG_WIDTH_PAIRS)
				width_pairs_reg = WIDTH_PAIRS_W'(val[k]);
			else if (idx[k] == CFG_FRAME_HEIGHT)
				height_reg = FRAME_HEIGHT_W'(val[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Driver: hold the macropixel until taken, then present the next or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ready) begin
				planar_writes_due.push_back(convert_macropixel(pix_data));
				pixels_taken++;
			end
			if (!pix_valid || pix_ready) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pix_valid <= 1'b1;
					pix_data  <= pixel_backlog.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each write transaction against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			wr_ready <= 1'b0;
		end else begin
			if (wr_valid && wr_ready) begin
				if (planar_writes_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected write: %s", show_write(wr_data));
				end else begin
					oldest_write = planar_writes_due.pop_front();
					if (wr_data.luma_address !== oldest_write.luma_address ||
							wr_data.luma_out_first !== oldest_write.luma_out_first ||
							wr_data.luma_out_second !== oldest_write.luma_out_second ||
							wr_data.chroma_address !== oldest_write.chroma_address ||
							wr_data.chroma_value !== oldest_write.chroma_value ||
							wr_data.chroma_is_red !== oldest_write.chroma_is_red ||
							wr_data.frame_done !== oldest_write.frame_done) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display("mismatch: expected %s, got %s",
								show_write(oldest_write), show_write(wr_data));
					end
				end
			end
			wr_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus
	initial begin
		int unsigned            random_pixels;
		int                     n;
		logic [CFG_DATA_W-1:0]  wp;
		logic [CFG_DATA_W-1:0]  rows;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry, field extremes
		queue_pixel(32'h0000_0000);
		queue_pixel(32'hFFFF_FFFF);
		queue_pixel(32'h0102_0304);
		settle();

		// Zero registers saturate to a 1x1 frame; the change mid-row ends the frame
		program_frame('0, '0, 1'b1);
		queue_pixel(32'hFF00_FF00);
		queue_pixel(32'h00FF_00FF);
		settle();

		// Upper width bit dropped (3 pairs), odd height: one full frame
		program_frame(13'h1003, 13'd3, 1'b0);
		repeat (9) queue_random_pixels(1);
		settle();

		// All ones saturate to the largest frame
		program_frame(13'h0FFF, 13'h1FFF, 1'b0);
		queue_pixel(32'hAA55_AA55);
		queue_pixel(32'h55AA_55AA);
		queue_random_pixels(2);
		settle();

		// Largest frame written exactly
		program_frame(CFG_DATA_W'(WIDTH_PAIRS_MAX), CFG_DATA_W'(HEIGHT_MAX), 1'b0);
		queue_random_pixels(3);
		settle();

		// One pair per row: alternate U and V rows
		program_frame(13'd1, 13'd2, 1'b0);
		queue_pixel(32'h0F1E_2D3C);
		queue_random_pixels(3);
		settle();

		// Walk the row counter deep, then widen to reach the top address bits
		send_idle_pct = 16;
		recv_idle_pct = 46;
		program_frame(13'd1, CFG_DATA_W'(HEIGHT_MAX), 1'b0);
		queue_random_pixels(DEEP_ROWS);
		settle();
		program_frame(CFG_DATA_W'(WIDTH_PAIRS_MAX), CFG_DATA_W'(HEIGHT_MAX), 1'b0);
		queue_random_pixels(4);

		// Random geometries, mostly small so frames complete often
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			settle();
			if (random_pixels < RANDOM_PIXELS / 3) begin
				send_idle_pct = 16;
				recv_idle_pct = 46;
			end else if (random_pixels < 2 * RANDOM_PIXELS / 3) begin
				send_idle_pct = 46;
				recv_idle_pct = 16;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(9))
				0: wp = '0;
				1: wp = CFG_DATA_W'($urandom);
				default: wp = CFG_DATA_W'($urandom_range(12, 1));
			endcase
			case ($urandom_range(9))
				0: rows = '0;
				1: rows = CFG_DATA_W'($urandom);
				default: rows = CFG_DATA_W'($urandom_range(7, 1));
			endcase
			program_frame(wp, rows, $urandom_range(7) == 0);
			n = $urandom_range(60, 20);
			queue_random_pixels(n);
			random_pixels += n;
		end

		settle();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && planar_writes_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
